// File: src/pbpf_pkg.sv
// Shared types and constants for the planar bitmap pixel fetch block.
package pbpf_pkg;

   localparam int MODE_W = 2;
   localparam int ADDR_W = 16;
   localparam int DATA_W = 8;
   localparam int LUT_CH_W = 2;
   localparam int LUT_IDX_W = 4;
   localparam int LINE_W = 8;
   localparam int COL_W = 5;
   localparam int LEVEL_W = 8;
   localparam int PIXEL_X_W = 9;
   localparam int PAGE_W = 3;
   localparam int PLANES = 4;
   localparam int PIX_IDX_W = 4;
   localparam int LUT_DEPTH = 16;
   localparam int VRAM_DEPTH = 65536;
   localparam int CHAN_EN_W = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 8;

   // Request mode codes.
   localparam logic [MODE_W-1:0] REQ_MODE_RAM_WR = 2'd0;
   localparam logic [MODE_W-1:0] REQ_MODE_LUT_WR = 2'd1;
   localparam logic [MODE_W-1:0] REQ_MODE_RENDER = 2'd2;

   // Colour table selects.
   localparam logic [LUT_CH_W-1:0] LUT_RED = 2'd0;
   localparam logic [LUT_CH_W-1:0] LUT_GREEN = 2'd1;
   localparam logic [LUT_CH_W-1:0] LUT_BLUE = 2'd2;

   // Register indexes on the CSR port.
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_MODE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCROLL_OFFSET = 2'd2;

   // Bit positions inside image_mode.
   localparam int IMG_UPRIGHT_BIT = 4;
   localparam int IMG_WIDE_BIT = 5;
   localparam int IMG_BLANK_BIT = 7;

   typedef struct packed {
      logic [CHAN_EN_W-1:0] channel_enable;
      logic [7:0]           image_mode;
      logic [LINE_W-1:0]    scroll_offset;
   } cfg_type;

   typedef enum logic [1:0] {
      CMD_RAM_WR,
      CMD_LUT_WR,
      CMD_RENDER
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                     kind;
      logic [ADDR_W-1:0]                address;
      logic [DATA_W-1:0]                data;
      logic [LUT_CH_W-1:0]              lut_channel;
      logic [LUT_IDX_W-1:0]             lut_index;
      logic [LINE_W-1:0]                line;
      logic [LINE_W-1:0]                row;
      logic [COL_W-1:0]                 column;
      logic                             wide;
      logic [PLANES-1:0][PAGE_W-1:0]    pages;
   } cmd_type;

   typedef enum logic {
      JOB_LUT_WR,
      JOB_RENDER
   } job_kind_type;

   typedef struct packed {
      job_kind_type                     kind;
      logic [DATA_W-1:0]                data;
      logic [LUT_CH_W-1:0]              lut_channel;
      logic [LUT_IDX_W-1:0]             lut_index;
      logic [LINE_W-1:0]                line;
      logic [COL_W-1:0]                 column;
      logic                             wide;
      logic [PLANES-1:0][DATA_W-1:0]    planes;
   } job_type;

endpackage

// File: src/pbpf_front.sv
// Front stage: accepts request words, drops ignored ones and decodes the rest.
module pbpf_front import pbpf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [MODE_W-1:0]    req_mode,
   input  logic [ADDR_W-1:0]    req_address,
   input  logic [DATA_W-1:0]    req_data,
   input  logic [LUT_CH_W-1:0]  req_lut_channel,
   input  logic [LUT_IDX_W-1:0] req_lut_index,
   input  logic [LINE_W-1:0]    req_line,
   input  logic [COL_W-1:0]     req_column,
   input  cfg_type              cfg,
   output logic                 cmd_valid,
   output cmd_type              cmd,
   input  logic                 cmd_ready
);

   logic              valid_ff, valid_in;
   cmd_type           cmd_ff, cmd_in, decoded;
   logic              keep;
   logic              accept;
   logic [LINE_W-1:0] row_scrolled;

   assign req_ready = !valid_ff || cmd_ready;
   assign accept    = req_valid && req_ready;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

   always_comb begin
      row_scrolled = req_line + cfg.scroll_offset;
      decoded = '0;
      decoded.address = req_address;
      decoded.data = req_data;
      decoded.lut_channel = req_lut_channel;
      decoded.lut_index = req_lut_index;
      decoded.line = req_line;
      decoded.column = req_column;
      // A flipped picture reads line (256 - y) mod 256.
      decoded.row = cfg.image_mode[IMG_UPRIGHT_BIT] ? row_scrolled
                                                    : LINE_W'(8'd0 - row_scrolled);
      decoded.wide = cfg.image_mode[IMG_WIDE_BIT];
      // In 512 mode pages 0 and 1 share select 0, pages 2 and 3 share select 1.
      for (int k = 0; k < PLANES; k++) begin
         decoded.pages[k] = {decoded.wide ? cfg.image_mode[k >> 1] : cfg.image_mode[k],
                             2'(k)};
      end
      keep = 1'b0;
      case (req_mode)
         REQ_MODE_RAM_WR: begin
            keep = 1'b1;
            decoded.kind = CMD_RAM_WR;
         end
         REQ_MODE_LUT_WR: begin
            keep = (req_lut_channel == LUT_RED) || (req_lut_channel == LUT_GREEN) ||
                   (req_lut_channel == LUT_BLUE);
            decoded.kind = CMD_LUT_WR;
         end
         REQ_MODE_RENDER: begin
            keep = 1'b1;
            decoded.kind = CMD_RENDER;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff && !cmd_ready;
      cmd_in = cmd_ff;
      if (accept) begin
         valid_in = keep;
         cmd_in = decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

// File: src/pbpf_queue.sv
// Command queue between the front stage and the fetch stage (DEPTH of 2 or more).
module pbpf_queue import pbpf_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: src/pbpf_fetch.sv
// Fetch stage: owns the video RAM, performs RAM writes and reads the four page bytes.
module pbpf_fetch import pbpf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_cmd,
   output logic    q_pop,
   output logic    job_valid,
   output job_type job,
   input  logic    job_ready
);

   localparam logic [1:0] LAST_PLANE = 2'(PLANES - 1);

   logic [DATA_W-1:0]              vram [VRAM_DEPTH];
   logic [PLANES-1:0][DATA_W-1:0]  planes_ff;
   logic [1:0]                     slot_ff, slot_in;
   logic                           job_valid_ff, job_valid_in;
   job_type                        meta_ff, meta_in;
   logic                           job_free;
   logic                           ram_we, ram_re;
   logic [ADDR_W-1:0]              ram_addr;

   // The job register can be refilled in the cycle the emitter takes it.
   assign job_free  = !job_valid_ff || job_ready;
   assign job_valid = job_valid_ff;

   always_comb begin
      job = meta_ff;
      job.planes = planes_ff;
   end

   always_comb begin
      q_pop = 1'b0;
      ram_we = 1'b0;
      ram_re = 1'b0;
      slot_in = slot_ff;
      meta_in = meta_ff;
      job_valid_in = job_valid_ff && !job_ready;
      ram_addr = {q_cmd.pages[slot_ff], q_cmd.row, q_cmd.column};
      if (q_valid) begin
         case (q_cmd.kind)
            CMD_RAM_WR: begin
               ram_we = 1'b1;
               ram_addr = q_cmd.address;
               q_pop = 1'b1;
            end
            CMD_LUT_WR: begin
               // Table writes travel through the emitter to stay behind earlier pixels.
               if (job_free) begin
                  q_pop = 1'b1;
                  job_valid_in = 1'b1;
                  meta_in.kind = JOB_LUT_WR;
                  meta_in.data = q_cmd.data;
                  meta_in.lut_channel = q_cmd.lut_channel;
                  meta_in.lut_index = q_cmd.lut_index;
               end
            end
            CMD_RENDER: begin
               if (job_free) begin
                  ram_re = 1'b1;
                  slot_in = slot_ff + 2'd1;
                  if (slot_ff == LAST_PLANE) begin
                     q_pop = 1'b1;
                     job_valid_in = 1'b1;
                     meta_in.kind = JOB_RENDER;
                     meta_in.line = q_cmd.line;
                     meta_in.column = q_cmd.column;
                     meta_in.wide = q_cmd.wide;
                  end
               end
            end
            default: begin
               q_pop = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         job_valid_ff <= job_valid_in;
      end
      meta_ff <= meta_in;
   end

   // Single-port RAM; the read lands straight in the plane register of its slot.
   always_ff @(posedge clock) begin
      if (ram_we) begin
         vram[ram_addr] <= q_cmd.data;
      end
      if (ram_re) begin
         planes_ff[slot_ff] <= vram[ram_addr];
      end
   end

endmodule

// File: src/pbpf_emit.sv
// Emit stage: colour tables and the pixel sequencer that drives the result channel.
module pbpf_emit import pbpf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 job_valid,
   input  job_type              job,
   output logic                 job_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [LEVEL_W-1:0]   rsp_red,
   output logic [LEVEL_W-1:0]   rsp_green,
   output logic [LEVEL_W-1:0]   rsp_blue,
   output logic [PIXEL_X_W-1:0] rsp_pixel_x,
   output logic [LINE_W-1:0]    rsp_pixel_y,
   output logic                 rsp_last
);

   typedef enum logic {
      EM_IDLE,
      EM_PIXELS
   } state_type;

   localparam logic [3:0] PIX_LAST_NARROW = 4'd7;
   localparam logic [3:0] PIX_LAST_WIDE = 4'd15;

   logic [LEVEL_W-1:0]             red_tab [LUT_DEPTH];
   logic [LEVEL_W-1:0]             green_tab [LUT_DEPTH];
   logic [LEVEL_W-1:0]             blue_tab [LUT_DEPTH];

   state_type                      state_ff, state_in;
   logic [3:0]                     cnt_ff, cnt_in;
   logic                           wide_ff;
   logic [COL_W-1:0]               column_ff;
   logic [LINE_W-1:0]              line_ff;
   logic [PLANES-1:0][DATA_W-1:0]  planes_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]             rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [PIXEL_X_W-1:0]           rsp_pixel_x_ff;
   logic [LINE_W-1:0]              rsp_pixel_y_ff;
   logic                           rsp_last_ff;

   logic                           adv, emit_now, last_px, take, blank;
   logic [2:0]                     bit_sel;
   logic [PIX_IDX_W-1:0]           pix_index;
   logic [PIXEL_X_W-1:0]           pix_x;
   logic [LEVEL_W-1:0]             red_lvl, green_lvl, blue_lvl;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign emit_now  = (state_ff == EM_PIXELS) && adv;
   assign last_px   = wide_ff ? (cnt_ff == PIX_LAST_WIDE) : (cnt_ff == PIX_LAST_NARROW);
   assign job_ready = (state_ff == EM_IDLE) || (emit_now && last_px);
   assign take      = job_valid && job_ready;
   assign blank     = cfg.image_mode[IMG_BLANK_BIT];

   always_comb begin
      bit_sel = wide_ff ? cnt_ff[3:1] : cnt_ff[2:0];
      if (wide_ff) begin
         // Two pixels per bit: pages 2/0 give the even one, pages 3/1 the odd one.
         pix_index = cnt_ff[0] ? {planes_ff[3][bit_sel], 1'b0, planes_ff[1][bit_sel], 1'b0}
                               : {planes_ff[2][bit_sel], 1'b0, planes_ff[0][bit_sel], 1'b0};
         pix_x = {column_ff, ~bit_sel, cnt_ff[0]};
      end else begin
         pix_index = {planes_ff[3][bit_sel], planes_ff[2][bit_sel],
                      planes_ff[1][bit_sel], planes_ff[0][bit_sel]};
         pix_x = {1'b0, column_ff, ~bit_sel};
      end
      red_lvl   = (!blank && cfg.channel_enable[0]) ? red_tab[pix_index] : '0;
      green_lvl = (!blank && cfg.channel_enable[1]) ? green_tab[pix_index] : '0;
      blue_lvl  = (!blank && cfg.channel_enable[2]) ? blue_tab[pix_index] : '0;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit_now) begin
         rsp_valid_in = 1'b1;
         cnt_in = cnt_ff + 4'd1;
         if (last_px) begin
            state_in = EM_IDLE;
         end
      end
      if (take && (job.kind == JOB_RENDER)) begin
         state_in = EM_PIXELS;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EM_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take && (job.kind == JOB_RENDER)) begin
         wide_ff <= job.wide;
         column_ff <= job.column;
         line_ff <= job.line;
         planes_ff <= job.planes;
      end
      if (emit_now) begin
         rsp_red_ff <= red_lvl;
         rsp_green_ff <= green_lvl;
         rsp_blue_ff <= blue_lvl;
         rsp_pixel_x_ff <= pix_x;
         rsp_pixel_y_ff <= line_ff;
         rsp_last_ff <= last_px;
      end
   end

   always_ff @(posedge clock) begin
      if (take && (job.kind == JOB_LUT_WR)) begin
         case (job.lut_channel)
            LUT_RED: begin
               red_tab[job.lut_index] <= job.data;
            end
            LUT_GREEN: begin
               green_tab[job.lut_index] <= job.data;
            end
            LUT_BLUE: begin
               blue_tab[job.lut_index] <= job.data;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_red     = rsp_red_ff;
   assign rsp_green   = rsp_green_ff;
   assign rsp_blue    = rsp_blue_ff;
   assign rsp_pixel_x = rsp_pixel_x_ff;
   assign rsp_pixel_y = rsp_pixel_y_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

// File: src/planar_bitmap_pixel_fetch.sv
// Top level of the planar bitmap pixel fetch block.
//
//   Channel  Direction  Handshake          Word
//   req_*    in         valid / ready      RAM write, colour table write or byte-group render
//   rsp_*    out        valid / ready      one pixel: levels, position, last flag
//   csr_*    in         write enable only  channel_enable, image_mode, scroll_offset
//
// A render word gives 8 pixels (256 mode) or 16 pixels (512 mode), one per cycle while
// rsp_ready is high, so the pixel sequencer sets the sustained rate of render words.
// The four page bytes come from the single-port video RAM one after another, overlapped
// with the pixels of the previous word. A colour table write waits until the pixels
// ahead of it are out, so one placed between two render words stalls the page reads
// of the second word and leaves a gap in the pixel output.
// Reset clears control state only; video RAM and colour tables hold no reset value.
// A stall on rsp_* backs up through the emitter, the fetch stage, the command queue and the front stage.
module planar_bitmap_pixel_fetch import pbpf_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [ADDR_W-1:0]      req_address,
   input  logic [DATA_W-1:0]      req_data,
   input  logic [LUT_CH_W-1:0]    req_lut_channel,
   input  logic [LUT_IDX_W-1:0]   req_lut_index,
   input  logic [LINE_W-1:0]      req_line,
   input  logic [COL_W-1:0]       req_column,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [LEVEL_W-1:0]     rsp_red,
   output logic [LEVEL_W-1:0]     rsp_green,
   output logic [LEVEL_W-1:0]     rsp_blue,
   output logic [PIXEL_X_W-1:0]   rsp_pixel_x,
   output logic [LINE_W-1:0]      rsp_pixel_y,
   output logic                   rsp_last,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    cmd_valid, cmd_ready;
   cmd_type cmd;
   logic    q_valid, q_pop;
   cmd_type q_cmd;
   logic    job_valid, job_ready;
   job_type job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CHANNEL_ENABLE: begin
               cfg_in.channel_enable = csr_wdata[CHAN_EN_W-1:0];
            end
            CSR_IMAGE_MODE: begin
               cfg_in.image_mode = csr_wdata;
            end
            CSR_SCROLL_OFFSET: begin
               cfg_in.scroll_offset = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pbpf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_address     (req_address),
      .req_data        (req_data),
      .req_lut_channel (req_lut_channel),
      .req_lut_index   (req_lut_index),
      .req_line        (req_line),
      .req_column      (req_column),
      .cfg             (cfg_ff),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_ready       (cmd_ready)
   );

   pbpf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cmd_valid),
      .push_ready (cmd_ready),
      .push_cmd   (cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_pop),
      .pop_cmd    (q_cmd)
   );

   pbpf_fetch u_fetch (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .job_valid (job_valid),
      .job       (job),
      .job_ready (job_ready)
   );

   pbpf_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .job_valid   (job_valid),
      .job         (job),
      .job_ready   (job_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue),
      .rsp_pixel_x (rsp_pixel_x),
      .rsp_pixel_y (rsp_pixel_y),
      .rsp_last    (rsp_last)
   );

endmodule

// File: src/pbpf_checker.sv
// Port-level checks for the planar bitmap pixel fetch block, bound to the top level.
module pbpf_port_checks (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic [8:0] rsp_pixel_x,
   input logic [7:0] rsp_pixel_y,
   input logic       rsp_last
);

   // After reset nothing is pending on the result side.
   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // After reset the front stage is empty and takes a word.
   a_reset_req_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("request not ready right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green) &&
         $stable(rsp_blue) && $stable(rsp_pixel_x) && $stable(rsp_pixel_y) &&
         $stable(rsp_last))
      else $error("stalled result word changed");

   // The last pixel of a group is the leftmost bit of the byte: x = column*8 in 256 mode,
   // x = column*16 + 1 in 512 mode.
   a_last_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |->
         (rsp_pixel_x[8] == 1'b0 && rsp_pixel_x[2:0] == 3'd0) ||
         (rsp_pixel_x[3:0] == 4'd1))
      else $error("last flag on a pixel that does not end a byte group");

endmodule

bind planar_bitmap_pixel_fetch pbpf_port_checks u_pbpf_port_checks (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_red     (rsp_red),
   .rsp_green   (rsp_green),
   .rsp_blue    (rsp_blue),
   .rsp_pixel_x (rsp_pixel_x),
   .rsp_pixel_y (rsp_pixel_y),
   .rsp_last    (rsp_last)
);

// File: tb/pbpf_checker.sv
// Pixel checker: predicts the pixels of every rendered byte group and compares the output words.
module pbpf_checker import pbpf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [ADDR_W-1:0]      req_address,
   input  logic [DATA_W-1:0]      req_data,
   input  logic [LUT_CH_W-1:0]    req_lut_channel,
   input  logic [LUT_IDX_W-1:0]   req_lut_index,
   input  logic [LINE_W-1:0]      req_line,
   input  logic [COL_W-1:0]       req_column,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [LEVEL_W-1:0]     rsp_red,
   input  logic [LEVEL_W-1:0]     rsp_green,
   input  logic [LEVEL_W-1:0]     rsp_blue,
   input  logic [PIXEL_X_W-1:0]   rsp_pixel_x,
   input  logic [LINE_W-1:0]      rsp_pixel_y,
   input  logic                   rsp_last,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned            pending_pixels,
   output int unsigned            error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [LEVEL_W-1:0]   red;
      logic [LEVEL_W-1:0]   green;
      logic [LEVEL_W-1:0]   blue;
      logic [PIXEL_X_W-1:0] x;
      logic [LINE_W-1:0]    y;
      logic                 last;
   } pixel_type;

   logic [DATA_W-1:0]    vram_copy [VRAM_DEPTH];
   logic [LEVEL_W-1:0]   level_table [3*LUT_DEPTH];
   logic [CHAN_EN_W-1:0] visible;
   logic [7:0]           image_bits;
   logic [LINE_W-1:0]    scroll;
   pixel_type            expected_pixels [$];

   initial begin
      pending_pixels = 0;
      error_count = 0;
   end

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [PIXEL_X_W-1:0] got,
                                input logic [PIXEL_X_W-1:0] want, input pixel_type want_px);
      if (got !== want)
         report($sformatf("%s of pixel x=%0d y=%0d: got %0h, expected %0h",
                          name, want_px.x, want_px.y, got, want));
   endtask

   function automatic pixel_type shade(input logic [PIX_IDX_W-1:0] idx,
                                       input logic [PIXEL_X_W-1:0] x,
                                       input logic [LINE_W-1:0] y, input logic last);
      pixel_type px;
      logic      show;
      show = !image_bits[IMG_BLANK_BIT];
      px.red   = (show && visible[LUT_RED])   ? level_table[{LUT_RED, idx}]   : '0;
      px.green = (show && visible[LUT_GREEN]) ? level_table[{LUT_GREEN, idx}] : '0;
      px.blue  = (show && visible[LUT_BLUE])  ? level_table[{LUT_BLUE, idx}]  : '0;
      px.x = x;
      px.y = y;
      px.last = last;
      return px;
   endfunction

   task automatic predict_group(input logic [LINE_W-1:0] line, input logic [COL_W-1:0] column);
      logic [LINE_W-1:0] row;
      logic              wide;
      logic [DATA_W-1:0] plane [PLANES];
      row = line + scroll;
      if (!image_bits[IMG_UPRIGHT_BIT])
         row = 8'd0 - row;
      wide = image_bits[IMG_WIDE_BIT];
      // Plane k lives on page k, four pages higher when its select bit is set. In 512 mode
      // planes 0 and 1 share select bit 0, planes 2 and 3 share select bit 1.
      for (int k = 0; k < PLANES; k++)
         plane[k] = vram_copy[{image_bits[wide ? k / 2 : k], 2'(k), row, column}];
      for (int b = 0; b < 8; b++) begin
         if (wide) begin
            expected_pixels.push_back(shade({plane[2][b], 1'b0, plane[0][b], 1'b0},
                                            {column, 4'(14 - 2*b)}, line, 1'b0));
            expected_pixels.push_back(shade({plane[3][b], 1'b0, plane[1][b], 1'b0},
                                            {column, 4'(15 - 2*b)}, line, b == 7));
         end else begin
            expected_pixels.push_back(shade({plane[3][b], plane[2][b], plane[1][b], plane[0][b]},
                                            {1'b0, column, 3'(7 - b)}, line, b == 7));
         end
      end
   endtask

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         visible = '0;
         image_bits = '0;
         scroll = '0;
         expected_pixels.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CHANNEL_ENABLE: visible = csr_wdata[CHAN_EN_W-1:0];
               CSR_IMAGE_MODE:     image_bits = csr_wdata;
               CSR_SCROLL_OFFSET:  scroll = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_mode)
               REQ_MODE_RAM_WR: vram_copy[req_address] = req_data;
               REQ_MODE_LUT_WR: begin
                  if (req_lut_channel <= LUT_BLUE)
                     level_table[{req_lut_channel, req_lut_index}] = req_data;
               end
               REQ_MODE_RENDER: predict_group(req_line, req_column);
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report($sformatf("pixel word x=%0d y=%0d with nothing expected",
                                rsp_pixel_x, rsp_pixel_y));
            end else begin
               want = expected_pixels.pop_front();
               compare_field("red", PIXEL_X_W'(rsp_red), PIXEL_X_W'(want.red), want);
               compare_field("green", PIXEL_X_W'(rsp_green), PIXEL_X_W'(want.green), want);
               compare_field("blue", PIXEL_X_W'(rsp_blue), PIXEL_X_W'(want.blue), want);
               compare_field("pixel_x", rsp_pixel_x, want.x, want);
               compare_field("pixel_y", PIXEL_X_W'(rsp_pixel_y), PIXEL_X_W'(want.y), want);
               compare_field("last", PIXEL_X_W'(rsp_last), PIXEL_X_W'(want.last), want);
            end
         end
      end
      pending_pixels <= expected_pixels.size();
   end

endmodule

// File: tb/tb.sv
// Testbench top: clock, reset, stimulus for the pixel fetch block and the final verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pbpf_pkg::*;

   localparam logic [MODE_W-1:0]      REQ_MODE_UNUSED = 2'd3;
   localparam logic [LUT_CH_W-1:0]    LUT_NONE = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVED = 2'd3;
   localparam int PHASES = 10;
   localparam int WORDS_PER_PHASE = 28;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT = 1000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [MODE_W-1:0]      req_mode;
   logic [ADDR_W-1:0]      req_address;
   logic [DATA_W-1:0]      req_data;
   logic [LUT_CH_W-1:0]    req_lut_channel;
   logic [LUT_IDX_W-1:0]   req_lut_index;
   logic [LINE_W-1:0]      req_line;
   logic [COL_W-1:0]       req_column;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [LEVEL_W-1:0]     rsp_red;
   logic [LEVEL_W-1:0]     rsp_green;
   logic [LEVEL_W-1:0]     rsp_blue;
   logic [PIXEL_X_W-1:0]   rsp_pixel_x;
   logic [LINE_W-1:0]      rsp_pixel_y;
   logic                   rsp_last;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int unsigned            pending_pixels;
   int unsigned            error_count;

   // Settings currently in the block, needed to find the bytes a render will fetch.
   logic [7:0]             cur_image_bits;
   logic [LINE_W-1:0]      cur_scroll;
   bit                     written [VRAM_DEPTH];
   logic [ADDR_W-1:0]      group_addr [PLANES];
   logic [LINE_W-1:0]      last_line;
   logic [COL_W-1:0]       last_column;
   int unsigned            word_count;
   int unsigned            req_gap_max;
   int unsigned            rsp_stall_max;

   planar_bitmap_pixel_fetch dut (.*);

   pbpf_checker pixel_check (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] address,
                            input logic [DATA_W-1:0] data, input logic [LUT_CH_W-1:0] chan,
                            input logic [LUT_IDX_W-1:0] index, input logic [LINE_W-1:0] line,
                            input logic [COL_W-1:0] column);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_address <= address;
      req_data <= data;
      req_lut_channel <= chan;
      req_lut_index <= index;
      req_line <= line;
      req_column <= column;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
      if (mode == REQ_MODE_RAM_WR)
         written[address] = 1'b1;
      if (mode != REQ_MODE_UNUSED && !(mode == REQ_MODE_LUT_WR && chan == LUT_NONE))
         word_count++;
   endtask

   // A render word is preceded by writes of any of its four plane bytes not yet written.
   task automatic render_group(input logic [LINE_W-1:0] line, input logic [COL_W-1:0] column);
      logic [LINE_W-1:0] row;
      logic              wide;
      row = line + cur_scroll;
      if (!cur_image_bits[IMG_UPRIGHT_BIT])
         row = 8'd0 - row;
      wide = cur_image_bits[IMG_WIDE_BIT];
      for (int k = 0; k < PLANES; k++) begin
         group_addr[k] = {cur_image_bits[wide ? k / 2 : k], 2'(k), row, column};
         if (!written[group_addr[k]])
            send_word(REQ_MODE_RAM_WR, group_addr[k], DATA_W'($urandom),
                      LUT_CH_W'($urandom), LUT_IDX_W'($urandom),
                      LINE_W'($urandom), COL_W'($urandom));
      end
      last_line = line;
      last_column = column;
      send_word(REQ_MODE_RENDER, ADDR_W'($urandom), DATA_W'($urandom), LUT_CH_W'($urandom),
                LUT_IDX_W'($urandom), line, column);
   endtask

   // Config writes need an idle block: all pixels out, then time for trailing table writes.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_pixels != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : rsp_side
      int unsigned hold;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         hold = $urandom_range(0, rsp_stall_max);
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid)
            @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [CHAN_EN_W-1:0]  enable;
      logic [7:0]            image_bits;
      logic [LINE_W-1:0]     scroll_lines;
      logic [CSR_DATA_W-1:0] junk;
      int unsigned           pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = '0;
      req_address = '0;
      req_data = '0;
      req_lut_channel = '0;
      req_lut_index = '0;
      req_line = '0;
      req_column = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cur_image_bits = '0;
      cur_scroll = '0;
      last_line = '0;
      last_column = '0;
      word_count = 0;
      req_gap_max = 0;
      rsp_stall_max = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin enable = 3'b111; image_bits = 8'h10; scroll_lines = 8'h00; end
            1: begin enable = 3'b111; image_bits = 8'h30; scroll_lines = 8'h00; end
            2: begin enable = 3'b000; image_bits = 8'h00; scroll_lines = 8'hFF; end
            3: begin enable = 3'b111; image_bits = 8'hFF; scroll_lines = 8'hFF; end
            4: begin enable = 3'b101; image_bits = 8'h0F; scroll_lines = 8'h80; end
            5: begin enable = 3'b010; image_bits = 8'h3A; scroll_lines = 8'h01; end
            6: begin enable = 3'b011; image_bits = 8'h65; scroll_lines = 8'hC3; end
            default: begin
               enable = CHAN_EN_W'($urandom);
               image_bits = 8'($urandom);
               scroll_lines = LINE_W'($urandom);
            end
         endcase
         settle();
         junk = CSR_DATA_W'($urandom);
         csr_we <= 1'b1;
         csr_index <= CSR_CHANNEL_ENABLE;
         csr_wdata <= {junk[CSR_DATA_W-1:CHAN_EN_W], enable};
         @(negedge clock);
         csr_index <= CSR_IMAGE_MODE;
         csr_wdata <= image_bits;
         @(negedge clock);
         csr_index <= CSR_SCROLL_OFFSET;
         csr_wdata <= scroll_lines;
         @(negedge clock);
         // The spare index names no register and must leave the others alone.
         csr_index <= CSR_RESERVED;
         csr_wdata <= CSR_DATA_W'($urandom);
         @(negedge clock);
         csr_we <= 1'b0;
         cur_image_bits = image_bits;
         cur_scroll = scroll_lines;
         req_gap_max = (phase % 4 == 1 || phase % 4 == 2) ? 5 : 0;
         rsp_stall_max = (phase % 4 == 1 || phase % 4 == 3) ? 5 : 0;

         if (phase == 0) begin
            // Fill every colour table entry before any render can look one up.
            for (int slot = 0; slot < 3*LUT_DEPTH; slot++)
               send_word(REQ_MODE_LUT_WR, ADDR_W'($urandom),
                         (slot == 0) ? 8'h00 :
                         (slot == 3*LUT_DEPTH - 1) ? 8'hFF : DATA_W'($urandom),
                         LUT_CH_W'(slot / LUT_DEPTH), LUT_IDX_W'(slot % LUT_DEPTH),
                         LINE_W'($urandom), COL_W'($urandom));
            send_word(REQ_MODE_RAM_WR, 16'h0000, 8'hFF, '0, '0, '0, '0);
            send_word(REQ_MODE_RAM_WR, 16'hFFFF, 8'h00, '1, '1, '1, '1);
            send_word(REQ_MODE_LUT_WR, ADDR_W'($urandom), 8'hAA, LUT_NONE, '1,
                      LINE_W'($urandom), COL_W'($urandom));
            send_word(REQ_MODE_UNUSED, '1, '1, '1, '1, '1, '1);
         end
         render_group('0, '0);
         render_group('1, '1);

         word_count = 0;
         while (word_count < WORDS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
               render_group(LINE_W'($urandom), COL_W'($urandom));
            else if (pick < 52)
               send_word(REQ_MODE_RAM_WR, group_addr[$urandom_range(0, PLANES - 1)],
                         DATA_W'($urandom), LUT_CH_W'($urandom), LUT_IDX_W'($urandom),
                         LINE_W'($urandom), COL_W'($urandom));
            else if (pick < 60)
               render_group(last_line, last_column);
            else if (pick < 75)
               send_word(REQ_MODE_RAM_WR, ADDR_W'($urandom), DATA_W'($urandom),
                         LUT_CH_W'($urandom), LUT_IDX_W'($urandom),
                         LINE_W'($urandom), COL_W'($urandom));
            else if (pick < 92)
               send_word(REQ_MODE_LUT_WR, ADDR_W'($urandom), DATA_W'($urandom),
                         LUT_CH_W'($urandom), LUT_IDX_W'($urandom),
                         LINE_W'($urandom), COL_W'($urandom));
            else
               send_word(REQ_MODE_UNUSED, ADDR_W'($urandom), DATA_W'($urandom),
                         LUT_CH_W'($urandom), LUT_IDX_W'($urandom),
                         LINE_W'($urandom), COL_W'($urandom));
         end
      end

      settle();
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
